>>> rtl/cekc_pkg.sv
// ----------------------------------------------------------------------------
// cekc_pkg: shared definitions for the clamped-edge kernel convolution
// Field widths, action and register codes, default sizes and the control
// and status bundles between the sequencer and the arithmetic unit.
// ----------------------------------------------------------------------------
package cekc_pkg;

    // default sizes
    localparam int DEF_KERNEL_SIZE = 9;
    localparam int DEF_MAX_WIDTH   = 64;
    localparam int DEF_MAX_HEIGHT  = 64;

    // field widths
    localparam int ACT_W     = 2;
    localparam int POS_W     = 6;
    localparam int PIX_W     = 16;
    localparam int CIDX_W    = 7;
    localparam int COEF_W    = 16;
    localparam int OUT_W     = 18;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int SZ_W      = 7;
    localparam int KS_W      = 24;

    // action codes
    localparam logic [ACT_W-1:0] ACT_LOAD_COEF   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WRITE_PIXEL = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REQUEST     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAST_MODE    = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 7'd64;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 7'd64;

    // 1.0 in Q2.14, divisor when the coefficients sum to zero
    localparam int ONE_Q14 = 16384;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // quotient bits resolved by the divider; anything larger saturates
    localparam int QUO_W = OUT_W;

    typedef struct packed {
        logic clear;      // zero the accumulator
        logic mac_en;     // pixel and coefficient operands valid
        logic div_start;  // accumulator final, start normalizing
    } arith_ctl_t;

    typedef struct packed {
        logic                     done;
        logic signed [OUT_W-1:0]  result;
    } arith_stat_t;

    // bit i set when i is a multiple of k
    function automatic logic [2**POS_W-1:0] grid_mask(input int k);
        logic [2**POS_W-1:0] m;
        int                  cnt;
        m   = '0;
        cnt = 0;
        for (int i = 0; i < 2**POS_W; i++)
        begin
            m[i] = (cnt == 0);
            cnt  = (cnt == k - 1) ? 0 : cnt + 1;
        end
        return m;
    endfunction

endpackage

>>> rtl/cekc_frame_mem.sv
// ----------------------------------------------------------------------------
// cekc_frame_mem: frame pixel store
// One write port and one read port, read data registered. Address is
// row * MAX_WIDTH + column.
// ----------------------------------------------------------------------------
module cekc_frame_mem #(
    parameter int MAX_WIDTH  = cekc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = cekc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                             clk,
    input  logic                                             wr_en,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          wr_addr,
    input  logic [cekc_pkg::PIX_W-1:0]                       wr_data,
    input  logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]          rd_addr,
    output logic [cekc_pkg::PIX_W-1:0]                       rd_data
);
    import cekc_pkg::*;

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;

    logic [PIX_W-1:0] frame_mem [DEPTH];
    logic [PIX_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= frame_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/cekc_kernel_bank.sv
// ----------------------------------------------------------------------------
// cekc_kernel_bank: kernel coefficient store and running coefficient sum
// Taps read back as zero until written. A write must follow a read of the
// same tap in the cycle before: the old value then on rd_data leaves the sum.
// ----------------------------------------------------------------------------
module cekc_kernel_bank #(
    parameter int KERNEL_SIZE = cekc_pkg::DEF_KERNEL_SIZE
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic [$clog2(KERNEL_SIZE*KERNEL_SIZE)-1:0]        rd_addr,
    output logic signed [cekc_pkg::COEF_W-1:0]                rd_data,
    input  logic                                              wr_en,
    input  logic [$clog2(KERNEL_SIZE*KERNEL_SIZE)-1:0]        wr_addr,
    input  logic signed [cekc_pkg::COEF_W-1:0]                wr_data,
    output logic signed [cekc_pkg::KS_W-1:0]                  ksum
);
    import cekc_pkg::*;

    localparam int TAPS = KERNEL_SIZE * KERNEL_SIZE;

    logic signed [COEF_W-1:0] kernel_mem [TAPS];
    logic signed [COEF_W-1:0] rd_word_reg;
    logic                     rd_ok_reg;
    logic                     rd_ok_next;
    logic [TAPS-1:0]          valid_reg;
    logic [TAPS-1:0]          valid_next;
    logic signed [KS_W-1:0]   ksum_reg;
    logic signed [KS_W-1:0]   ksum_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            kernel_mem[wr_addr] <= wr_data;
        end
        rd_word_reg <= kernel_mem[rd_addr];
    end

    always_comb
    begin
        valid_next = valid_reg;
        ksum_next  = ksum_reg;
        rd_ok_next = valid_reg[rd_addr];
        if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
            ksum_next = ksum_reg - KS_W'(rd_data) + KS_W'(wr_data);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_ok_reg <= 1'b0;
            ksum_reg  <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            rd_ok_reg <= rd_ok_next;
            ksum_reg  <= ksum_next;
        end
    end

    assign rd_data = rd_ok_reg ? rd_word_reg : '0;
    assign ksum    = ksum_reg;

endmodule

>>> rtl/cekc_arith.sv
// ----------------------------------------------------------------------------
// cekc_arith: shared multiply-accumulate and normalizing divider
// One multiplier feeds the window accumulator, one tap per cycle. On
// div_start the sum is divided by the coefficient sum with round to
// nearest (ties away from zero), one quotient bit per cycle, then saturated.
// ----------------------------------------------------------------------------
module cekc_arith #(
    parameter int KERNEL_SIZE = cekc_pkg::DEF_KERNEL_SIZE
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  cekc_pkg::arith_ctl_t                ctl,
    input  logic [cekc_pkg::PIX_W-1:0]          pix,
    input  logic signed [cekc_pkg::COEF_W-1:0]  coef,
    input  logic signed [cekc_pkg::KS_W-1:0]    ksum,
    output cekc_pkg::arith_stat_t               stat
);
    import cekc_pkg::*;

    localparam int TAPS   = KERNEL_SIZE * KERNEL_SIZE;
    localparam int PROD_W = PIX_W + COEF_W + 1;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int NUM_W  = ACC_W + 1;
    localparam int DEN_W  = KS_W + 1;
    localparam int CMP_W  = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;
    localparam int CNT_W  = $clog2(QUO_W);
    localparam int SQ_W   = QUO_W + 1;

    typedef enum logic [4:0] {
        A_IDLE  = 5'b00001,
        A_SCALE = 5'b00010,
        A_CHECK = 5'b00100,
        A_STEP  = 5'b01000,
        A_FIN   = 5'b10000
    } astate_t;

    astate_t                  st_reg, st_next;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic                     pv_reg, pv_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]         n_reg, n_next;
    logic [KS_W-1:0]          d_reg, d_next;
    logic                     neg_reg, neg_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic                     ovf_reg, ovf_next;
    logic [DEN_W-1:0]         rem_reg, rem_next;
    logic [QUO_W-1:0]         low_reg, low_next;
    logic [QUO_W-1:0]         q_reg, q_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic signed [OUT_W-1:0]  res_reg, res_next;
    logic                     done_reg, done_next;

    logic [DEN_W:0]           trial;
    logic [DEN_W:0]           diff;
    logic                     ge;
    logic signed [SQ_W-1:0]   sq;
    logic signed [SQ_W-1:0]   sv;

    assign prod_next = PROD_W'($signed({1'b0, pix})) * PROD_W'(coef);
    assign pv_next   = ctl.mac_en;

    assign trial = {rem_reg, low_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});
    assign sq    = $signed({1'b0, q_reg});
    assign sv    = neg_reg ? -sq : sq;

    always_comb
    begin
        st_next   = st_reg;
        acc_next  = acc_reg;
        n_next    = n_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        ovf_next  = ovf_reg;
        rem_next  = rem_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        res_next  = res_reg;
        done_next = 1'b0;

        if (ctl.clear)
        begin
            acc_next = '0;
        end
        else if (pv_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end

        unique case (st_reg)
            A_IDLE:
            begin
                if (ctl.div_start)
                begin
                    n_next = acc_reg[ACC_W-1] ? $unsigned(-acc_reg) : $unsigned(acc_reg);
                    if (ksum == '0)
                    begin
                        d_next = KS_W'(ONE_Q14);
                    end
                    else
                    begin
                        d_next = ksum[KS_W-1] ? $unsigned(-ksum) : $unsigned(ksum);
                    end
                    neg_next = acc_reg[ACC_W-1] ^ ksum[KS_W-1];
                    st_next  = A_SCALE;
                end
            end
            A_SCALE:
            begin
                // (2n + d) / (2d) rounds half away from zero
                num_next = (NUM_W'(n_reg) << 1) + NUM_W'(d_reg);
                den_next = DEN_W'(d_reg) << 1;
                st_next  = A_CHECK;
            end
            A_CHECK:
            begin
                ovf_next = (CMP_W'(num_reg) >= (CMP_W'(den_reg) << QUO_W));
                rem_next = DEN_W'(num_reg >> QUO_W);
                low_next = num_reg[QUO_W-1:0];
                q_next   = '0;
                cnt_next = '0;
                st_next  = ovf_next ? A_FIN : A_STEP;
            end
            A_STEP:
            begin
                rem_next = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                q_next   = {q_reg[QUO_W-2:0], ge};
                low_next = low_reg << 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    st_next = A_FIN;
                end
            end
            A_FIN:
            begin
                if (ovf_reg)
                begin
                    res_next = neg_reg ? OUT_MIN : OUT_MAX;
                end
                else if (sv > SQ_W'(OUT_MAX))
                begin
                    res_next = OUT_MAX;
                end
                else if (sv < SQ_W'(OUT_MIN))
                begin
                    res_next = OUT_MIN;
                end
                else
                begin
                    res_next = OUT_W'(sv);
                end
                done_next = 1'b1;
                st_next   = A_IDLE;
            end
            default:
            begin
                st_next = A_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        n_reg    <= n_next;
        d_reg    <= d_next;
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        ovf_reg  <= ovf_next;
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= A_IDLE;
            pv_reg   <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            pv_reg   <= pv_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    assign stat.done   = done_reg;
    assign stat.result = res_reg;

endmodule

>>> rtl/clamped_edge_kernel_convolution_top.sv
// ----------------------------------------------------------------------------
// clamped_edge_kernel_convolution_top: normalized 2D convolution, replicated
// border, over a stored frame
// Loads kernel taps, writes frame pixels, and answers filtered-value
// requests one at a time through a shared multiplier and divider.
// ----------------------------------------------------------------------------
// Timing: a pixel write goes straight to the frame store; a coefficient load
// reads the old tap, then writes the new one. A request walks the
// KERNEL_SIZE*KERNEL_SIZE window one tap per cycle through the single
// multiply-accumulate unit (address, memory read, multiply and accumulate
// stages), then normalizes in a divider that resolves one quotient bit per
// cycle. In fast mode an off-grid request answers zero without a window
// scan. The input is stalled while a transaction is in work; the result
// waits in an output register until taken. Frame pixels must be written
// before any request reads them.
// ----------------------------------------------------------------------------
module clamped_edge_kernel_convolution_top #(
    parameter int KERNEL_SIZE = cekc_pkg::DEF_KERNEL_SIZE,
    parameter int MAX_WIDTH   = cekc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT  = cekc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [cekc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cekc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cekc_pkg::ACT_W-1:0]          action,
    input  logic [cekc_pkg::POS_W-1:0]          x_position,
    input  logic [cekc_pkg::POS_W-1:0]          y_position,
    input  logic [cekc_pkg::PIX_W-1:0]          pixel_value,
    input  logic [cekc_pkg::CIDX_W-1:0]         coef_index,
    input  logic signed [cekc_pkg::COEF_W-1:0]  coef_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cekc_pkg::OUT_W-1:0]   filtered_value
);
    import cekc_pkg::*;

    localparam int TAPS      = KERNEL_SIZE * KERNEL_SIZE;
    localparam int HALF      = KERNEL_SIZE / 2;
    localparam int TC_W      = $clog2(KERNEL_SIZE);
    localparam int KI_W      = $clog2(TAPS);
    localparam int FA_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
    localparam int CRD_W     = $clog2(2**POS_W + KERNEL_SIZE) + 1;
    localparam int DRAIN_LEN = 4;
    localparam logic [2**POS_W-1:0] GRID = grid_mask(KERNEL_SIZE);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b0000001,
        S_COEF_RD = 7'b0000010,
        S_COEF_WR = 7'b0000100,
        S_SCAN    = 7'b0001000,
        S_DRAIN   = 7'b0010000,
        S_DIV     = 7'b0100000,
        S_DONE    = 7'b1000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CFG_W-1:0]         width_reg, width_next;
    logic [CFG_W-1:0]         height_reg, height_next;
    logic                     fast_reg, fast_next;
    logic [POS_W-1:0]         x_reg, x_next;
    logic [POS_W-1:0]         y_reg, y_next;
    logic [SZ_W-1:0]          w_act_reg, w_act_next;
    logic [SZ_W-1:0]          h_act_reg, h_act_next;
    logic [KI_W-1:0]          cidx_reg, cidx_next;
    logic signed [COEF_W-1:0] cval_reg, cval_next;
    logic [TC_W-1:0]          row_reg, row_next;
    logic [TC_W-1:0]          col_reg, col_next;
    logic [KI_W-1:0]          tap_reg, tap_next;
    logic [FA_W-1:0]          fa_reg, fa_next;
    logic [KI_W-1:0]          kidx_reg, kidx_next;
    logic                     v1_reg, v1_next;
    logic                     v2_reg, v2_next;
    logic [1:0]               drain_reg, drain_next;
    logic signed [OUT_W-1:0]  hold_reg, hold_next;
    logic                     out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0]  out_value_reg, out_value_next;

    logic                     in_acc;
    logic                     scan_v;
    logic                     frame_we;
    logic [FA_W-1:0]          frame_waddr;
    logic                     pix_in_range;
    logic                     grid_hit;
    logic [PIX_W-1:0]         pix_rd;
    logic signed [COEF_W-1:0] coef_rd;
    logic [KI_W-1:0]          k_rd_addr;
    logic                     k_we;
    logic signed [KS_W-1:0]   ksum;
    logic signed [CRD_W-1:0]  tx;
    logic signed [CRD_W-1:0]  ty;
    logic [SZ_W-1:0]          tx_c;
    logic [SZ_W-1:0]          ty_c;
    arith_ctl_t               ctl;
    arith_stat_t              stat;

    function automatic logic [SZ_W-1:0] clamp_crd(input logic signed [CRD_W-1:0] v,
                                                   input logic [SZ_W-1:0] size);
        logic signed [CRD_W-1:0] lim;
        lim = $signed(CRD_W'(size));
        if (v < 0)
        begin
            return '0;
        end
        else if (v >= lim)
        begin
            return size - SZ_W'(1);
        end
        return SZ_W'(v);
    endfunction

    function automatic logic [SZ_W-1:0] active_size(input logic [CFG_W-1:0] r,
                                                     input int max_size);
        if (r == '0)
        begin
            return SZ_W'(1);
        end
        else if (int'(r) > max_size)
        begin
            return SZ_W'(max_size);
        end
        return SZ_W'(r);
    endfunction

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;

    assign pix_in_range = (int'(x_position) < MAX_WIDTH) && (int'(y_position) < MAX_HEIGHT);
    assign frame_waddr  = FA_W'(y_position) * FA_W'(MAX_WIDTH) + FA_W'(x_position);
    assign grid_hit     = GRID[x_position] || GRID[y_position];

    // window tap coordinates, clamped to the active frame
    assign tx   = $signed(CRD_W'(x_reg)) + $signed(CRD_W'(col_reg)) - $signed(CRD_W'(HALF));
    assign ty   = $signed(CRD_W'(y_reg)) + $signed(CRD_W'(row_reg)) - $signed(CRD_W'(HALF));
    assign tx_c = clamp_crd(tx, w_act_reg);
    assign ty_c = clamp_crd(ty, h_act_reg);

    assign k_rd_addr = (state_reg == S_COEF_RD) ? cidx_reg : kidx_reg;
    assign k_we      = (state_reg == S_COEF_WR);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        fast_next   = fast_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  width_next  = cfg_data;
                REG_FRAME_HEIGHT: height_next = cfg_data;
                REG_FAST_MODE:    fast_next   = cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        w_act_next     = w_act_reg;
        h_act_next     = h_act_reg;
        cidx_next      = cidx_reg;
        cval_next      = cval_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        tap_next       = tap_reg;
        drain_next     = drain_reg;
        hold_next      = hold_reg;
        out_value_next = out_value_reg;
        out_valid_next = out_valid_reg;
        frame_we       = 1'b0;
        scan_v         = 1'b0;
        ctl            = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    unique case (action)
                        ACT_LOAD_COEF:
                        begin
                            if (int'(coef_index) < TAPS)
                            begin
                                cidx_next  = KI_W'(coef_index);
                                cval_next  = coef_value;
                                state_next = S_COEF_RD;
                            end
                        end
                        ACT_WRITE_PIXEL:
                        begin
                            frame_we = pix_in_range;
                        end
                        ACT_REQUEST:
                        begin
                            if (fast_reg && !grid_hit)
                            begin
                                hold_next  = '0;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                x_next     = x_position;
                                y_next     = y_position;
                                w_act_next = active_size(width_reg, MAX_WIDTH);
                                h_act_next = active_size(height_reg, MAX_HEIGHT);
                                row_next   = '0;
                                col_next   = '0;
                                tap_next   = '0;
                                ctl.clear  = 1'b1;
                                state_next = S_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_COEF_RD:
            begin
                state_next = S_COEF_WR;
            end
            S_COEF_WR:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                scan_v   = 1'b1;
                tap_next = tap_reg + 1'b1;
                if (col_reg == TC_W'(KERNEL_SIZE - 1))
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                    if (row_reg == TC_W'(KERNEL_SIZE - 1))
                    begin
                        drain_next = '0;
                        state_next = S_DRAIN;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // wait out the address, read, multiply and accumulate stages
                drain_next = drain_reg + 1'b1;
                if (drain_reg == 2'(DRAIN_LEN - 1))
                begin
                    ctl.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.done)
                begin
                    hold_next  = stat.result;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_value_next = hold_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        ctl.mac_en = v2_reg;
    end

    assign v1_next   = scan_v;
    assign v2_next   = v1_reg;
    assign fa_next   = FA_W'(ty_c) * FA_W'(MAX_WIDTH) + FA_W'(tx_c);
    assign kidx_next = tap_reg;

    always_ff @(posedge clk)
    begin
        x_reg         <= x_next;
        y_reg         <= y_next;
        w_act_reg     <= w_act_next;
        h_act_reg     <= h_act_next;
        cidx_reg      <= cidx_next;
        cval_reg      <= cval_next;
        fa_reg        <= fa_next;
        kidx_reg      <= kidx_next;
        hold_reg      <= hold_next;
        out_value_reg <= out_value_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            width_reg     <= FRAME_WIDTH_RST;
            height_reg    <= FRAME_HEIGHT_RST;
            fast_reg      <= 1'b0;
            row_reg       <= '0;
            col_reg       <= '0;
            tap_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            drain_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            fast_reg      <= fast_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            tap_reg       <= tap_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    cekc_frame_mem #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_frame (
        .clk     (clk),
        .wr_en   (frame_we),
        .wr_addr (frame_waddr),
        .wr_data (pixel_value),
        .rd_addr (fa_reg),
        .rd_data (pix_rd)
    );

    cekc_kernel_bank #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_kernel (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (k_rd_addr),
        .rd_data (coef_rd),
        .wr_en   (k_we),
        .wr_addr (cidx_reg),
        .wr_data (cval_reg),
        .ksum    (ksum)
    );

    cekc_arith #(
        .KERNEL_SIZE (KERNEL_SIZE)
    ) u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .pix   (pix_rd),
        .coef  (coef_rd),
        .ksum  (ksum),
        .stat  (stat)
    );

    assign out_valid      = out_valid_reg;
    assign filtered_value = out_value_reg;

endmodule
